// ===== rtl/csvft_pkg.sv =====
package csvft_pkg;

    localparam int unsigned MAX_COLUMNS = 255;
    localparam logic [7:0] COLUMN_CAP = (MAX_COLUMNS < 255) ? 8'(MAX_COLUMNS) : 8'd255;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] DELIMITER_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2
    } kind_t;

    typedef struct packed {
        logic        in_quotes;
        logic        quote_pending;
        logic        record_open;
        logic [7:0]  column_count;
        logic [31:0] record_count;
    } parse_state_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  field_byte;
        logic [7:0]  column;
        logic [31:0] record;
    } result_t;

endpackage

// ===== rtl/csvft_cfg.sv =====
module csvft_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [csvft_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    output logic [7:0]                       delimiter_char,
    output logic [7:0]                       quote_char
);
    import csvft_pkg::*;

    logic [7:0] delimiter_reg;
    logic [7:0] delimiter_next;
    logic [7:0] quote_reg;
    logic [7:0] quote_next;

    always_comb
    begin
        delimiter_next = delimiter_reg;
        quote_next = quote_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_DELIMITER: delimiter_next = cfg_data;
                CFG_QUOTE:     quote_next = cfg_data;
                default:       delimiter_next = delimiter_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIMITER_RESET;
            quote_reg <= QUOTE_RESET;
        end
        else
        begin
            delimiter_reg <= delimiter_next;
            quote_reg <= quote_next;
        end
    end

    assign delimiter_char = delimiter_reg;
    assign quote_char = quote_reg;

endmodule

// ===== rtl/csvft_step.sv =====
module csvft_step (
    input  csvft_pkg::parse_state_t state_cur,
    input  logic [7:0]              data_byte,
    input  logic                    end_of_input,
    input  logic [7:0]              delimiter_char,
    input  logic [7:0]              quote_char,
    output csvft_pkg::parse_state_t state_nxt,
    output csvft_pkg::result_t      result
);
    import csvft_pkg::*;

    logic unquoted;
    logic do_close;

    always_comb
    begin
        state_nxt = state_cur;
        result.valid = 1'b0;
        result.kind = KIND_DATA;
        result.field_byte = 8'd0;
        result.column = state_cur.column_count;
        result.record = state_cur.record_count;
        unquoted = 1'b0;
        do_close = 1'b0;

        if (end_of_input)
        begin
            if (state_cur.record_open || state_cur.in_quotes || state_cur.quote_pending)
            begin
                result.valid = 1'b1;
                result.kind = KIND_RECORD_END;
                do_close = 1'b1;
            end
        end
        else if (state_cur.in_quotes)
        begin
            if (state_cur.quote_pending)
            begin
                state_nxt.quote_pending = 1'b0;
                if (data_byte == quote_char)
                begin
                    result.valid = 1'b1;
                    result.field_byte = data_byte;
                end
                else
                begin
                    // The run is closed and this byte is taken as unquoted.
                    state_nxt.in_quotes = 1'b0;
                    unquoted = 1'b1;
                end
            end
            else if (data_byte == quote_char)
            begin
                state_nxt.quote_pending = 1'b1;
            end
            else
            begin
                state_nxt.record_open = 1'b1;
                result.valid = 1'b1;
                result.field_byte = data_byte;
            end
        end
        else
        begin
            unquoted = 1'b1;
        end

        if (unquoted)
        begin
            if (data_byte == quote_char)
            begin
                state_nxt.in_quotes = 1'b1;
                state_nxt.record_open = 1'b1;
            end
            else if (data_byte == NEWLINE_BYTE)
            begin
                result.valid = 1'b1;
                result.kind = KIND_RECORD_END;
                do_close = 1'b1;
            end
            else
            begin
                state_nxt.record_open = 1'b1;
                result.valid = 1'b1;
                if (data_byte == delimiter_char)
                begin
                    result.kind = KIND_FIELD_END;
                    if (state_cur.column_count < COLUMN_CAP)
                    begin
                        state_nxt.column_count = state_cur.column_count + 8'd1;
                    end
                end
                else
                begin
                    result.field_byte = data_byte;
                end
            end
        end

        if (do_close)
        begin
            state_nxt.in_quotes = 1'b0;
            state_nxt.quote_pending = 1'b0;
            state_nxt.record_open = 1'b0;
            state_nxt.column_count = 8'd0;
            if (state_cur.record_count != 32'hFFFF_FFFF)
            begin
                state_nxt.record_count = state_cur.record_count + 32'd1;
            end
        end
    end

endmodule

// ===== rtl/csv_field_tokenizer_unit.sv =====
// Requests pass from the request register through the parse step into
// the result register. Throughput: one request per cycle while the result
// register is free or drained, set by the combinational parse step.
// Requests that produce no result never occupy the result register.
// Reset clears the parse state, the valid flags and restores the default
// delimiter and quote bytes.
module csv_field_tokenizer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [csvft_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              request_valid,
    output logic                              request_ready,
    input  logic [7:0]                        data_byte,
    input  logic                              end_of_input,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [1:0]                        kind,
    output logic [7:0]                        field_byte,
    output logic [7:0]                        column,
    output logic [31:0]                       record
);
    import csvft_pkg::*;

    logic [7:0]   delimiter_char;
    logic [7:0]   quote_char;

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_eoi_reg;

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      step_result;

    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_reg;

    logic         advance;

    csvft_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .delimiter_char (delimiter_char),
        .quote_char     (quote_char)
    );

    csvft_step u_step (
        .state_cur      (state_reg),
        .data_byte      (in_byte_reg),
        .end_of_input   (in_eoi_reg),
        .delimiter_char (delimiter_char),
        .quote_char     (quote_char),
        .state_nxt      (state_next),
        .result         (step_result)
    );

    assign advance = in_valid_reg
        && (!out_valid_reg || result_ready || !step_result.valid);
    assign request_ready = !in_valid_reg || advance;
    assign in_valid_next = request_ready ? request_valid : in_valid_reg;
    assign out_valid_next = (out_valid_reg && !result_ready)
        || (advance && step_result.valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (request_valid && request_ready)
        begin
            in_byte_reg <= data_byte;
            in_eoi_reg <= end_of_input;
        end
        if (advance && step_result.valid)
        begin
            out_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind = out_reg.kind;
    assign field_byte = out_reg.field_byte;
    assign column = out_reg.column;
    assign record = out_reg.record;

    a_pending_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.quote_pending |-> state_reg.in_quotes)
        else $error("quote pending outside a quoted run");

    a_record_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_result.valid && step_result.kind == KIND_RECORD_END)
        |=> (state_reg.column_count == 8'd0) && !state_reg.in_quotes
            && !state_reg.record_open)
        else $error("record end did not clear the parse state");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("parse state changed without a request");

    a_eoi_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eoi_reg) |=> !state_reg.record_open && !state_reg.in_quotes)
        else $error("end of input left a record open");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_result.valid) |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten");

endmodule

// ===== verif/csv_field_tokenizer_unit_tb.sv =====
module csv_field_tokenizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csvft_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  field_byte;
        logic [7:0]  column;
        logic [31:0] record;
    } token_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic       fixed;
        token_t     tok;
    } byte_req_t;

    localparam token_t NO_TOKEN = '{KIND_DATA, 8'h00, 8'h00, 32'h0};

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_DELIMITER;
    logic [7:0]             cfg_data = 8'h00;
    logic                   request_valid = 1'b0;
    logic                   request_ready;
    logic [7:0]             data_byte;
    logic                   end_of_input;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic [1:0]             kind;
    logic [7:0]             field_byte;
    logic [7:0]             column;
    logic [31:0]            record;

    byte_req_t cur_req = '{8'h00, 1'b0, 1'b0, NO_TOKEN};
    byte_req_t pending_bytes [$];
    token_t    expected_tokens [$];

    logic [7:0]  gen_delim = DELIMITER_RESET;
    logic [7:0]  gen_quote = QUOTE_RESET;

    logic [7:0]  fmt_delim = DELIMITER_RESET;
    logic [7:0]  fmt_quote = QUOTE_RESET;
    logic        in_run = 1'b0;
    logic        quote_seen = 1'b0;
    logic        rec_open = 1'b0;
    logic [7:0]  col_idx = 8'h00;
    logic [31:0] rec_idx = 32'h0;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int          stall_mode = 0;
    int          stall_left = 0;

    logic [7:0] phase_delim [1:7] = '{8'h00, 8'hFF, 8'h09, 8'h7C, NEWLINE_BYTE, 8'h2C, 8'h00};
    logic [7:0] phase_quote [1:7] = '{8'hFF, 8'h00, 8'h27, 8'h7C, 8'h22, NEWLINE_BYTE, 8'h00};

    byte_req_t directed_rows [0:24] = '{
        '{8'h00, 1'b1, 1'b0, NO_TOKEN},
        '{8'h61, 1'b0, 1'b1, '{KIND_DATA, 8'h61, 8'd0, 32'd0}},
        '{8'h2C, 1'b0, 1'b1, '{KIND_FIELD_END, 8'h00, 8'd0, 32'd0}},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h2C, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0A, 1'b0, 1'b0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h2C, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0D, 1'b0, 1'b0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b1, '{KIND_DATA, 8'hFF, 8'd2, 32'd0}},
        '{8'h41, 1'b1, 1'b1, '{KIND_RECORD_END, 8'h00, 8'd2, 32'd0}},
        '{8'h0A, 1'b0, 1'b1, '{KIND_RECORD_END, 8'h00, 8'd0, 32'd1}},
        '{8'h00, 1'b0, 1'b1, '{KIND_DATA, 8'h00, 8'd0, 32'd2}},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0A, 1'b0, 1'b0, NO_TOKEN},
        '{8'h2C, 1'b0, 1'b0, NO_TOKEN},
        '{8'h2C, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b1, 1'b1, '{KIND_RECORD_END, 8'h00, 8'd2, 32'd3}},
        '{8'h00, 1'b1, 1'b0, NO_TOKEN},
        '{8'h7F, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0A, 1'b0, 1'b0, NO_TOKEN}
    };

    assign data_byte = cur_req.data;
    assign end_of_input = cur_req.eoi;

    csv_field_tokenizer_unit uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(30, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= ($urandom_range(0, 3) != 0);
            2: result_ready <= ((cycle_count % 7) > 2);
            default: result_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 50)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic void next_record();
        in_run = 1'b0;
        quote_seen = 1'b0;
        rec_open = 1'b0;
        col_idx = 8'h00;
        if (rec_idx != 32'hFFFF_FFFF)
        begin
            rec_idx = rec_idx + 32'd1;
        end
    endfunction

    function automatic bit predict_token(input logic [7:0] b, input logic eoi,
                                         output token_t tok);
        tok = '{KIND_DATA, 8'h00, col_idx, rec_idx};
        if (eoi)
        begin
            if (!(rec_open || in_run || quote_seen))
            begin
                return 1'b0;
            end
            tok.kind = KIND_RECORD_END;
            next_record();
            return 1'b1;
        end
        if (in_run)
        begin
            if (quote_seen)
            begin
                quote_seen = 1'b0;
                if (b == fmt_quote)
                begin
                    tok.field_byte = b;
                    return 1'b1;
                end
                in_run = 1'b0;
            end
            else if (b == fmt_quote)
            begin
                quote_seen = 1'b1;
                return 1'b0;
            end
            else
            begin
                rec_open = 1'b1;
                tok.field_byte = b;
                return 1'b1;
            end
        end
        if (b == fmt_quote)
        begin
            in_run = 1'b1;
            rec_open = 1'b1;
            return 1'b0;
        end
        if (b == NEWLINE_BYTE)
        begin
            tok.kind = KIND_RECORD_END;
            next_record();
            return 1'b1;
        end
        rec_open = 1'b1;
        if (b == fmt_delim)
        begin
            tok.kind = KIND_FIELD_END;
            if (col_idx < COLUMN_CAP)
            begin
                col_idx = col_idx + 8'd1;
            end
            return 1'b1;
        end
        tok.field_byte = b;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        token_t tok;
        token_t got;
        token_t want;
        bit     has_tok;
        if (!rst_n)
        begin
            fmt_delim = DELIMITER_RESET;
            fmt_quote = QUOTE_RESET;
            in_run = 1'b0;
            quote_seen = 1'b0;
            rec_open = 1'b0;
            col_idx = 8'h00;
            rec_idx = 32'h0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                got = '{kind_t'(kind), field_byte, column, record};
                if (expected_tokens.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h col %0d rec %0d",
                                              got.kind, got.field_byte, got.column, got.record));
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                    if (got.field_byte != want.field_byte)
                        report_mismatch($sformatf("field_byte %02h, expected %02h",
                                                  got.field_byte, want.field_byte));
                    if (got.column != want.column)
                        report_mismatch($sformatf("column %0d, expected %0d",
                                                  got.column, want.column));
                    if (got.record != want.record)
                        report_mismatch($sformatf("record %0d, expected %0d",
                                                  got.record, want.record));
                end
            end
            // A directed request with a hand-written result queues that result instead.
            if (request_valid && request_ready)
            begin
                has_tok = predict_token(data_byte, end_of_input, tok);
                if (cur_req.fixed)
                    expected_tokens.push_back(cur_req.tok);
                else if (has_tok)
                    expected_tokens.push_back(tok);
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_DELIMITER)
                    fmt_delim = cfg_data;
                else
                    fmt_quote = cfg_data;
            end
        end
    end

    function automatic void push_byte(input logic [7:0] b, input logic eoi);
        pending_bytes.push_back('{b, eoi, 1'b0, NO_TOKEN});
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == gen_quote || b == gen_delim || b == NEWLINE_BYTE);
        return b;
    endfunction

    function automatic void add_record(input int fields);
        int ending;
        for (int f = 0; f < fields; f++)
        begin
            if (f != 0)
                push_byte(gen_delim, 1'b0);
            case ($urandom_range(0, 3))
                0: ;
                1: repeat ($urandom_range(1, 6)) push_byte(plain_byte(), 1'b0);
                default:
                begin
                    push_byte(gen_quote, 1'b0);
                    repeat ($urandom_range(0, 6))
                    begin
                        case ($urandom_range(0, 5))
                            0:
                            begin
                                push_byte(gen_quote, 1'b0);
                                push_byte(gen_quote, 1'b0);
                            end
                            1: push_byte(gen_delim, 1'b0);
                            2: push_byte(NEWLINE_BYTE, 1'b0);
                            default: push_byte(plain_byte(), 1'b0);
                        endcase
                    end
                    push_byte(gen_quote, 1'b0);
                end
            endcase
        end
        ending = $urandom_range(0, 19);
        if (ending < 15)
        begin
            push_byte(NEWLINE_BYTE, 1'b0);
        end
        else if (ending < 18)
        begin
            push_byte(8'($urandom), 1'b1);
        end
        else
        begin
            push_byte(NEWLINE_BYTE, 1'b0);
            push_byte(8'($urandom), 1'b1);
        end
    endfunction

    function automatic void add_noise(input int count);
        repeat (count)
        begin
            case ($urandom_range(0, 7))
                0: push_byte(gen_quote, 1'b0);
                1: push_byte(NEWLINE_BYTE, 1'b0);
                2: push_byte(gen_delim, 1'b0);
                3: push_byte(8'($urandom), ($urandom_range(0, 3) == 0));
                default: push_byte(8'($urandom), 1'b0);
            endcase
        end
    endfunction

    function automatic void fill_random(input int target);
        while (pending_bytes.size() < target)
        begin
            if ($urandom_range(0, 9) == 0)
                add_noise($urandom_range(1, 12));
            else
                add_record($urandom_range(1, 6));
        end
    endfunction

    task automatic send_bytes();
        int burst_left;
        int gap;
        burst_left = 0;
        while (pending_bytes.size() != 0)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    burst_left = $urandom_range(50, 200);
                else
                    burst_left = $urandom_range(1, 24);
            end
            cur_req <= pending_bytes.pop_front();
            request_valid <= 1'b1;
            @(posedge clk);
            while (!(request_valid && request_ready))
                @(posedge clk);
            @(negedge clk);
            burst_left--;
            gap = 0;
            if (burst_left == 0 && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 10);
            if (gap != 0 || pending_bytes.size() == 0)
            begin
                request_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_format(input logic [7:0] delim, input logic [7:0] quote);
        cfg_write <= 1'b1;
        cfg_index <= CFG_DELIMITER;
        cfg_data <= delim;
        @(negedge clk);
        cfg_index <= CFG_QUOTE;
        cfg_data <= quote;
        @(negedge clk);
        cfg_write <= 1'b0;
        gen_delim = delim;
        gen_quote = quote;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            pending_bytes.push_back(directed_rows[i]);
        send_bytes();

        // A wide record drives the column index into saturation.
        repeat (270) push_byte(gen_delim, 1'b0);
        push_byte(8'h7A, 1'b0);
        push_byte(NEWLINE_BYTE, 1'b0);
        fill_random(400);
        send_bytes();

        for (int p = 1; p < 8; p++)
        begin
            wait_idle();
            if (p == 7)
                set_format(8'($urandom), 8'($urandom));
            else
                set_format(phase_delim[p], phase_quote[p]);
            fill_random(220);
            send_bytes();
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
